### rtl/rks_pkg.sv
// shared types and constants of the record key sorter
package rks_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int ID_W  = 8;
  localparam int CAP_W = 16;
  localparam int MIL_W = 24;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CAP_W-1:0] capacity;
    logic [MIL_W-1:0] mileage;
  } rec_t;

  typedef enum logic [1:0] {
    StLoad,
    StSort,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic sort_done;
    logic last_one;
  } status_t;

endpackage

### rtl/rks_ifs.sv
// valid/ready channel interfaces for record input and sorted output
interface rks_in_if;
  import rks_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  record_id;
  logic [CAP_W-1:0] capacity;
  logic [MIL_W-1:0] mileage;
  logic             last_in;

  modport source (output valid, record_id, capacity, mileage, last_in, input ready);
  modport sink   (input valid, record_id, capacity, mileage, last_in, output ready);
endinterface

interface rks_out_if;
  import rks_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  out_id;
  logic [CAP_W-1:0] out_capacity;
  logic [MIL_W-1:0] out_mileage;
  logic             last_out;
  logic             dropped;

  modport source (output valid, out_id, out_capacity, out_mileage, last_out, dropped,
                  input ready);
  modport sink   (input valid, out_id, out_capacity, out_mileage, last_out, dropped,
                  output ready);
endinterface

### rtl/rks_ctrl.sv
// controller state machine: load, sort and emit phases
module rks_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rks_pkg::status_t status_i,
  output rks_pkg::cmd_t    cmd_o
);
  import rks_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad: begin
        if (in_valid_i && in_last_i) state_d = StSort;
      end
      StSort: begin
        if (status_i.sort_done) state_d = StEmit;
      end
      StEmit: begin
        if (out_ready_i && status_i.last_one) state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StLoad: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
        cmd_o.start = in_valid_i && in_last_i;
      end
      StSort: begin
        cmd_o.step = !status_i.sort_done;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        cmd_o.shift = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/rks_datapath.sv
// record cell row with odd-even transposition compare network and counters
module rks_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rks_pkg::cmd_t           cmd_i,
  output rks_pkg::status_t        status_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_wdata_i,
  input  rks_pkg::rec_t           in_rec_i,
  output rks_pkg::rec_t           out_rec_o,
  output logic                    last_o,
  output logic                    dropped_o
);
  import rks_pkg::*;

  rec_t             cell_q [MAX_RECORDS];
  logic [MAX_RECORDS-2:0] swap;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pass_q, pass_d;
  logic             drop_q, drop_d;
  logic             key_sel_q;
  logic             sort_key_q, sort_key_d;
  logic             full;

  function automatic logic [MIL_W-1:0] rec_key(input rec_t r, input logic ksel);
    return ksel ? r.mileage : MIL_W'(r.capacity);
  endfunction

  assign full = (count_q == CNT_W'(MAX_RECORDS));

  // compare network, one comparator per adjacent pair
  for (genvar j = 0; j < MAX_RECORDS - 1; j++) begin : g_pair
    localparam logic             ODD = ((j % 2) == 1);
    localparam logic [CNT_W-1:0] UPR = CNT_W'(j + 1);
    assign swap[j] = (pass_q[0] == ODD) && (UPR < count_q) &&
                     (rec_key(cell_q[j], sort_key_q) > rec_key(cell_q[j+1], sort_key_q));
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    rec_t cell_d;
    rec_t up_w;
    rec_t dn_w;
    logic swap_up;
    logic swap_dn;

    if (i < MAX_RECORDS - 1) begin : g_up
      assign up_w    = cell_q[i+1];
      assign swap_up = swap[i];
    end else begin : g_top
      assign up_w    = cell_q[i];
      assign swap_up = 1'b0;
    end

    if (i > 0) begin : g_dn
      assign dn_w    = cell_q[i-1];
      assign swap_dn = swap[i-1];
    end else begin : g_bot
      assign dn_w    = cell_q[i];
      assign swap_dn = 1'b0;
    end

    always_comb begin
      cell_d = cell_q[i];
      if (cmd_i.load && (count_q == IDX)) begin
        cell_d = in_rec_i;
      end else if (cmd_i.shift) begin
        cell_d = up_w;
      end else if (cmd_i.step) begin
        if (swap_up) begin
          cell_d = up_w;
        end else if (swap_dn) begin
          cell_d = dn_w;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[i] <= cell_d;
    end
  end

  always_comb begin
    count_d    = count_q;
    pass_d     = pass_q;
    drop_d     = drop_q;
    sort_key_d = sort_key_q;
    if (cmd_i.load) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.start) begin
      pass_d     = '0;
      sort_key_d = key_sel_q;
    end
    if (cmd_i.step) begin
      pass_d = pass_q + CNT_W'(1);
    end
    if (cmd_i.shift) begin
      count_d = count_q - CNT_W'(1);
      if (status_o.last_one) drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      pass_q     <= '0;
      drop_q     <= 1'b0;
      key_sel_q  <= 1'b0;
      sort_key_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      pass_q     <= pass_d;
      drop_q     <= drop_d;
      sort_key_q <= sort_key_d;
      if (cfg_we_i) key_sel_q <= cfg_wdata_i;
    end
  end

  assign status_o.sort_done = (pass_q == count_q);
  assign status_o.last_one  = (count_q == CNT_W'(1));

  assign out_rec_o = cell_q[0];
  assign last_o    = status_o.last_one;
  assign dropped_o = drop_q;

endmodule

### rtl/record_key_sorter.sv
// record key sorter top level: load, stable ascending sort, sorted emit
//
//   port     dir  role
//   rec_i    in   one vehicle record per transfer, last_in ends the load
//   res_o    out  records in ascending key order, last_out on the final one
//   cfg_*    in   key_select write, 0 capacity, 1 mileage
//
// each record of a load is one transfer on rec_i, which accepts one per cycle while loading
// after the last transfer the sort makes n odd-even passes for n stored records,
// one pass of the 64-cell compare row per cycle
// results then leave one per cycle while res_o.ready is high
// rec_i.ready is low from the last transfer until the final result leaves
// no clearing pass after reset
module record_key_sorter (
  input  logic  clk_i,
  input  logic  rst_ni,
  rks_in_if.sink    rec_i,
  rks_out_if.source res_o,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i
);
  import rks_pkg::*;

  cmd_t    cmd;
  status_t status;
  rec_t    in_rec;
  rec_t    out_rec;

  assign in_rec.id       = rec_i.record_id;
  assign in_rec.capacity = rec_i.capacity;
  assign in_rec.mileage  = rec_i.mileage;

  rks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rec_i.valid),
    .in_last_i   (rec_i.last_in),
    .in_ready_o  (rec_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rks_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_rec_i    (in_rec),
    .out_rec_o   (out_rec),
    .last_o      (res_o.last_out),
    .dropped_o   (res_o.dropped)
  );

  assign res_o.out_id       = out_rec.id;
  assign res_o.out_capacity = out_rec.capacity;
  assign res_o.out_mileage  = out_rec.mileage;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rec_i.ready && res_o.valid))
    else $error("input and output open at once");

  a_last_in_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_i.valid && rec_i.ready && rec_i.last_in) |=> !rec_i.ready)
    else $error("input still open after last transfer");

  a_last_out_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && res_o.last_out) |=> (rec_i.ready && !res_o.valid))
    else $error("load not restarted after final result");

  a_drop_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !res_o.last_out) |=> (res_o.valid && $stable(res_o.dropped)))
    else $error("drop flag changed within one emit");
`endif

endmodule
